### hdl/ttb_pkg.sv
// ----------------------------------------------------------------------------
// ttb_pkg: shared types and constants for the triangle tangent unit
// Field widths, the job handed from front to back, and the normalize request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ttb_pkg;

	localparam int PosW   = 32;   // corner position, Q16.16
	localparam int UvW    = 24;   // texture coordinate, Q8.16
	localparam int EdgeW  = 33;   // position difference
	localparam int DuvW   = 25;   // uv difference
	localparam int ProdW  = DuvW + EdgeW;
	localparam int DetW   = 51;   // determinant of the uv deltas
	localparam int VecW   = 59;   // raw tangent / bitangent component
	localparam int MagW   = 58;   // magnitude of a raw component
	localparam int OutW   = 16;   // Q1.15 result component
	localparam int InDataW  = 3 * PosW + 2 * UvW;
	localparam int OutDataW = 6 * OutW;

	// corner index within a triangle
	localparam logic [1:0] CornerFirst  = 2'd0;
	localparam logic [1:0] CornerSecond = 2'd1;
	localparam logic [1:0] CornerLast   = 2'd2;

	typedef struct packed {
		logic [2:0][EdgeW-1:0] e1;
		logic [2:0][EdgeW-1:0] e2;
		logic [DuvW-1:0]       du1;
		logic [DuvW-1:0]       dv1;
		logic [DuvW-1:0]       du2;
		logic [DuvW-1:0]       dv2;
	} ttb_job_t;

	typedef struct packed {
		logic                 start;
		logic [2:0][MagW-1:0] mag;
		logic [2:0]           neg;
	} ttb_ureq_t;

	typedef struct packed {
		logic                 done;
		logic [2:0][OutW-1:0] vec;
	} ttb_ursp_t;

endpackage

`default_nettype wire

### hdl/ttb_front.sv
// ----------------------------------------------------------------------------
// ttb_front: corner intake
// Holds the first two corners of a triangle and, on the third, forms the
// edges and uv deltas as one job for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttb_front import ttb_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic signed [PosW-1:0] pos_x,
	input  wire logic signed [PosW-1:0] pos_y,
	input  wire logic signed [PosW-1:0] pos_z,
	input  wire logic signed [UvW-1:0]  tex_u,
	input  wire logic signed [UvW-1:0]  tex_v,
	output logic                        job_valid,
	input  wire logic                   job_ready,
	output ttb_job_t                    job
);

	logic [1:0]                  cnt_q;
	logic signed [2:0][PosW-1:0] p0_q, p1_q;
	logic signed [UvW-1:0]       u0_q, v0_q, u1_q, v1_q;
	logic                        accept;
	logic [2:0][PosW-1:0]        p_in;

	assign p_in = {pos_z, pos_y, pos_x};

	// the third corner needs room in the queue, the others do not
	assign in_ready  = (cnt_q != CornerLast) || job_ready;
	assign job_valid = in_valid && (cnt_q == CornerLast);
	assign accept    = in_valid && in_ready;

	// count corners
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CornerFirst;
		end else if (accept) begin
			cnt_q <= (cnt_q == CornerLast) ? CornerFirst : cnt_q + 2'd1;
		end
	end

	// hold the first two corners
	always_ff @(posedge clk) begin
		if (accept && cnt_q == CornerFirst) begin
			p0_q <= p_in;
			u0_q <= tex_u;
			v0_q <= tex_v;
		end
		if (accept && cnt_q == CornerSecond) begin
			p1_q <= p_in;
			u1_q <= tex_u;
			v1_q <= tex_v;
		end
	end

	// form edges and uv deltas
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			job.e1[k] = EdgeW'($signed(p1_q[k])) - EdgeW'($signed(p0_q[k]));
			job.e2[k] = EdgeW'($signed(p_in[k])) - EdgeW'($signed(p0_q[k]));
		end
		job.du1 = DuvW'(u1_q) - DuvW'(u0_q);
		job.dv1 = DuvW'(v1_q) - DuvW'(v0_q);
		job.du2 = DuvW'(tex_u) - DuvW'(u0_q);
		job.dv2 = DuvW'(tex_v) - DuvW'(v0_q);
	end

endmodule

`default_nettype wire

### hdl/ttb_queue.sv
// ----------------------------------------------------------------------------
// ttb_queue: two-entry queue
// Decouples corner intake from the arithmetic back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttb_queue #(
	parameter int Width = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [Width-1:0] in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [Width-1:0]      out_data
);

	logic [Width-1:0] ent_q [2];
	logic             wr_q, rd_q;
	logic [1:0]       cnt_q;
	logic             push, pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = ent_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= in_data;
	end

endmodule

`default_nettype wire

### hdl/ttb_unit.sv
// ----------------------------------------------------------------------------
// ttb_unit: vector normalizer
// Scales three magnitudes so the largest tops out at bit 30, sums squares,
// takes an integer square root bit-serially and divides each component by
// restoring division into a saturated Q1.15 value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttb_unit import ttb_pkg::*; #(
	parameter int UNIT_FRAC_BITS = 15
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire ttb_ureq_t req,
	output ttb_ursp_t      rsp
);

	localparam int QW   = UNIT_FRAC_BITS + 2;
	localparam int NumW = UNIT_FRAC_BITS + 34;
	localparam int ItW  = $clog2(QW + 1);

	typedef enum logic [2:0] {U_IDLE, U_SHIFT, U_SQ, U_SQRT, U_LOAD, U_DIV} ust_t;

	ust_t                 st_q;
	logic [MagW-1:0]      m_q [3];
	logic [2:0]           neg_q;
	logic [MagW-1:0]      mx_q;
	logic [1:0]           k_q;
	logic [61:0]          sq_s1;
	logic [63:0]          s_q, x_q, res_q, bit_q;
	logic [31:0]          r_q;
	logic [NumW-1:0]      rem_q, dsh_q;
	logic [QW-1:0]        q_q;
	logic [ItW-1:0]       it_q;
	logic [2:0][OutW-1:0] o_q;
	logic                 done_q;
	logic [MagW-1:0]      mx_in;
	logic [63:0]          trial;
	logic [31:0]          q32;
	logic [16:0]          qs;
	logic [OutW-1:0]      o_val;

	assign rsp.done = done_q;
	assign rsp.vec  = o_q;

	// largest of the incoming magnitudes
	always_comb begin
		mx_in = req.mag[0];
		if (req.mag[1] > mx_in) mx_in = req.mag[1];
		if (req.mag[2] > mx_in) mx_in = req.mag[2];
	end

	assign trial = res_q + bit_q;

	// saturate and sign the finished quotient
	always_comb begin
		q32   = 32'(q_q);
		qs    = (q32 > 32'd32768) ? 17'd32768 : q32[16:0];
		o_val = neg_q[k_q] ? OutW'(-qs)
		      : ((qs[16] || qs[15]) ? 16'h7fff : qs[15:0]);
	end

	// sequence one vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= U_IDLE;
			done_q <= 1'b0;
			k_q    <= 2'd0;
			it_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				U_IDLE: begin
					if (req.start) st_q <= U_SHIFT;
				end
				U_SHIFT: begin
					if (mx_q[MagW-1:31] == '0 && mx_q[30]) begin
						st_q <= U_SQ;
						k_q  <= 2'd0;
					end
				end
				U_SQ: begin
					if (k_q == 2'd3) begin
						st_q <= U_SQRT;
						k_q  <= 2'd0;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				U_SQRT: begin
					if (bit_q[0]) st_q <= U_LOAD;
				end
				U_LOAD: begin
					st_q <= U_DIV;
					it_q <= '0;
				end
				U_DIV: begin
					if (it_q == ItW'(QW)) begin
						if (k_q == 2'd2) begin
							st_q   <= U_IDLE;
							done_q <= 1'b1;
						end else begin
							st_q <= U_LOAD;
							k_q  <= k_q + 2'd1;
						end
					end else begin
						it_q <= it_q + 1'b1;
					end
				end
				default: st_q <= U_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (st_q)
			U_IDLE: begin
				if (req.start) begin
					for (int k = 0; k < 3; k++) m_q[k] <= req.mag[k];
					neg_q <= req.neg;
					mx_q  <= mx_in;
				end
			end
			U_SHIFT: begin
				// move the leading one to bit 30, coarse steps first
				priority if (mx_q[MagW-1:39] != '0) begin
					for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] >> 8;
					mx_q <= mx_q >> 8;
				end else if (mx_q[MagW-1:31] != '0) begin
					for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] >> 1;
					mx_q <= mx_q >> 1;
				end else if (mx_q[30:23] == '0) begin
					for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] << 8;
					mx_q <= mx_q << 8;
				end else if (!mx_q[30]) begin
					for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] << 1;
					mx_q <= mx_q << 1;
				end else begin
					s_q <= '0;
				end
			end
			U_SQ: begin
				if (k_q != 2'd3) sq_s1 <= m_q[k_q][30:0] * m_q[k_q][30:0];
				if (k_q != 2'd0) s_q <= s_q + 64'(sq_s1);
				if (k_q == 2'd3) begin
					x_q   <= s_q + 64'(sq_s1);
					res_q <= '0;
					bit_q <= 64'd1 << 62;
				end
			end
			U_SQRT: begin
				if (x_q >= trial) begin
					x_q   <= x_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				if (bit_q[0]) r_q <= 32'((x_q >= trial) ? (res_q >> 1) + bit_q : res_q >> 1);
			end
			U_LOAD: begin
				rem_q <= NumW'({m_q[k_q][30:0], {(UNIT_FRAC_BITS + 1){1'b0}}}) + NumW'(r_q);
				dsh_q <= NumW'({r_q, 1'b0}) << (QW - 1);
				q_q   <= '0;
			end
			U_DIV: begin
				if (it_q == ItW'(QW)) begin
					o_q[k_q] <= o_val;
				end else begin
					if (rem_q >= dsh_q) begin
						rem_q <= rem_q - dsh_q;
						q_q   <= {q_q[QW-2:0], 1'b1};
					end else begin
						q_q <= {q_q[QW-2:0], 1'b0};
					end
					dsh_q <= dsh_q >> 1;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

### hdl/ttb_back.sv
// ----------------------------------------------------------------------------
// ttb_back: tangent back end
// Takes one job at a time, forms the determinant and the raw tangent and
// bitangent with one shared multiplier, normalizes both unless the triangle is
// degenerate and holds the result in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttb_back import ttb_pkg::*; #(
	parameter int UNIT_FRAC_BITS = 15
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          job_valid,
	output logic               job_ready,
	input  wire ttb_job_t      job,
	output logic               res_valid,
	input  wire logic          res_ready,
	output logic [OutDataW-1:0] res_data,
	output logic               res_degen
);

	typedef enum logic [2:0] {
		B_IDLE, B_MUL, B_CHECK, B_TSTART, B_TWAIT, B_BSTART, B_BWAIT, B_DONE
	} bst_t;

	bst_t                     st_q;
	ttb_job_t                 job_q;
	logic [3:0]               step_q;
	logic signed [ProdW-1:0]  prod_s1;
	logic signed [DetW-1:0]   det_q;
	logic signed [VecW-1:0]   t_q [3];
	logic signed [VecW-1:0]   b_q [3];
	logic                     degen_q;
	logic [2:0][OutW-1:0]     tan_q, bit_q;
	logic                     out_valid_q;
	logic [OutDataW-1:0]      out_data_q;
	logic                     out_degen_q;
	logic signed [DuvW-1:0]   mul_a;
	logic signed [EdgeW-1:0]  mul_b;
	logic [3:0]               j;
	logic [1:0]               comp;
	ttb_ureq_t                ureq;
	ttb_ursp_t                ursp;
	logic                     degen_now;
	logic                     out_free;

	assign job_ready = (st_q == B_IDLE);
	assign res_valid = out_valid_q;
	assign res_data  = out_data_q;
	assign res_degen = out_degen_q;
	assign out_free  = !out_valid_q || res_ready;
	assign j         = step_q - 4'd1;

	// pick multiplier operands for each product
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (step_q)
			4'd0:  begin mul_a = job_q.du1; mul_b = EdgeW'($signed(job_q.dv2)); end
			4'd1:  begin mul_a = job_q.dv1; mul_b = EdgeW'($signed(job_q.du2)); end
			4'd2:  begin mul_a = job_q.dv2; mul_b = job_q.e1[0]; end
			4'd3:  begin mul_a = job_q.dv1; mul_b = job_q.e2[0]; end
			4'd4:  begin mul_a = job_q.dv2; mul_b = job_q.e1[1]; end
			4'd5:  begin mul_a = job_q.dv1; mul_b = job_q.e2[1]; end
			4'd6:  begin mul_a = job_q.dv2; mul_b = job_q.e1[2]; end
			4'd7:  begin mul_a = job_q.dv1; mul_b = job_q.e2[2]; end
			4'd8:  begin mul_a = job_q.du1; mul_b = job_q.e2[0]; end
			4'd9:  begin mul_a = job_q.du2; mul_b = job_q.e1[0]; end
			4'd10: begin mul_a = job_q.du1; mul_b = job_q.e2[1]; end
			4'd11: begin mul_a = job_q.du2; mul_b = job_q.e1[1]; end
			4'd12: begin mul_a = job_q.du1; mul_b = job_q.e2[2]; end
			4'd13: begin mul_a = job_q.du2; mul_b = job_q.e1[2]; end
			default: ;
		endcase
	end

	// component that the previous product lands in
	always_comb begin
		unique case (j[3:1])
			3'd1, 3'd4: comp = 2'd0;
			3'd2, 3'd5: comp = 2'd1;
			3'd3, 3'd6: comp = 2'd2;
			default:    comp = 2'd0;
		endcase
	end

	assign degen_now = (det_q == '0)
		|| (t_q[0] == '0 && t_q[1] == '0 && t_q[2] == '0)
		|| (b_q[0] == '0 && b_q[1] == '0 && b_q[2] == '0);

	// normalize request: tangent first, then bitangent
	always_comb begin
		ureq.start = (st_q == B_TSTART) || (st_q == B_BSTART);
		for (int k = 0; k < 3; k++) begin
			if (st_q == B_BSTART) begin
				ureq.mag[k] = MagW'(b_q[k][VecW-1] ? -b_q[k] : b_q[k]);
				ureq.neg[k] = b_q[k][VecW-1] ^ det_q[DetW-1];
			end else begin
				ureq.mag[k] = MagW'(t_q[k][VecW-1] ? -t_q[k] : t_q[k]);
				ureq.neg[k] = t_q[k][VecW-1] ^ det_q[DetW-1];
			end
		end
	end

	ttb_unit #(.UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ureq),
		.rsp    (ursp)
	);

	// sequence one triangle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load the output register or drop a taken result
			if (st_q == B_DONE && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && res_ready) out_valid_q <= 1'b0;
			unique case (st_q)
				B_IDLE: begin
					if (job_valid) begin
						st_q   <= B_MUL;
						step_q <= '0;
					end
				end
				B_MUL: begin
					if (step_q == 4'd14) st_q <= B_CHECK;
					else step_q <= step_q + 4'd1;
				end
				B_CHECK:  st_q <= degen_now ? B_DONE : B_TSTART;
				B_TSTART: st_q <= B_TWAIT;
				B_TWAIT:  if (ursp.done) st_q <= B_BSTART;
				B_BSTART: st_q <= B_BWAIT;
				B_BWAIT:  if (ursp.done) st_q <= B_DONE;
				B_DONE: begin
					if (out_free) st_q <= B_IDLE;
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (st_q == B_IDLE && job_valid) job_q <= job;
		if (st_q == B_MUL) begin
			if (step_q != 4'd14) prod_s1 <= mul_a * mul_b;
			if (step_q != 4'd0) begin
				if (j == 4'd0) begin
					det_q <= DetW'(prod_s1);
				end else if (j == 4'd1) begin
					det_q <= det_q - DetW'(prod_s1);
				end else if (j < 4'd8) begin
					t_q[comp] <= j[0] ? t_q[comp] - VecW'(prod_s1) : VecW'(prod_s1);
				end else begin
					b_q[comp] <= j[0] ? b_q[comp] - VecW'(prod_s1) : VecW'(prod_s1);
				end
			end
		end
		if (st_q == B_CHECK) begin
			degen_q <= degen_now;
			tan_q   <= '0;
			bit_q   <= '0;
		end
		if (st_q == B_TWAIT && ursp.done) tan_q <= ursp.vec;
		if (st_q == B_BWAIT && ursp.done) bit_q <= ursp.vec;
		if (st_q == B_DONE && out_free) begin
			out_data_q  <= {bit_q, tan_q};
			out_degen_q <= degen_q;
		end
	end

endmodule

`default_nettype wire

### hdl/triangle_tangent_bitangent_top.sv
// Corners 0 and 1 of a triangle are taken in one cycle each.
// With the back end free, the third corner yields its result after intake, the
// products and the output register plus two normalizations (shift search,
// bit-serial square root, restoring divide). A degenerate triangle skips the
// normalizations. The two-entry queue lets corners of later triangles be taken
// while the back end works; arst_n clears all control.
// ----------------------------------------------------------------------------
// triangle_tangent_bitangent_top: triangle tangent / bitangent unit
// Streams corners in and unit tangent and bitangent vectors out, one per
// triangle, with zero vectors for a degenerate triangle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module triangle_tangent_bitangent_top import ttb_pkg::*; #(
	parameter int UNIT_FRAC_BITS = 15
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// pos_x, pos_y, pos_z, tex_u, tex_v
	input  wire logic [InDataW-1:0]  s_tdata,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y, bitangent_z
	output logic [OutDataW-1:0]      m_tdata,
	// degenerate
	output logic                     m_tuser
);

	logic     job_valid, job_ready;
	ttb_job_t job;
	logic     q_valid, q_ready;
	ttb_job_t q_job;

	ttb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.pos_x     (s_tdata[31:0]),
		.pos_y     (s_tdata[63:32]),
		.pos_z     (s_tdata[95:64]),
		.tex_u     (s_tdata[119:96]),
		.tex_v     (s_tdata[143:120]),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job)
	);

	ttb_queue #(.Width($bits(ttb_job_t))) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (job_valid),
		.in_ready  (job_ready),
		.in_data   (job),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_data  (q_job)
	);

	ttb_back #(.UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job_ready (q_ready),
		.job       (q_job),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res_data  (m_tdata),
		.res_degen (m_tuser)
	);

endmodule

`default_nettype wire

### hdl/ttb_checker.sv
// ----------------------------------------------------------------------------
// ttb_checker: port-level checks for the triangle tangent unit
// Watches the result stream and its degenerate flag, and that handshakes and offered requests are known.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttb_checker import ttb_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_tvalid,
	input wire logic                s_tready,
	input wire logic [InDataW-1:0]  s_tdata,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [OutDataW-1:0] m_tdata,
	input wire logic                m_tuser
);

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// degenerate results carry zero vectors
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("degenerate result with nonzero vectors");

	// good results carry nonzero tangent and bitangent
	a_good_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[47:0] != '0 && m_tdata[95:48] != '0)
		else $error("good result with a zero vector");

	// handshake outputs are always known once out of reset
	a_ctrl_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({s_tready, m_tvalid}))
		else $error("unknown handshake output");

	// an offered request carries known data
	a_req_known: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid |-> !$isunknown(s_tdata))
		else $error("request offered with unknown data");

endmodule

bind triangle_tangent_bitangent_top ttb_checker u_ttb_checker (.*);

`default_nettype wire
